>>> hdl/lightmap_extent_calc_defines.svh
// assertion macros shared by the lightmap extent calculator
`ifndef LIGHTMAP_EXTENT_CALC_DEFINES_SVH
`define LIGHTMAP_EXTENT_CALC_DEFINES_SVH

// cond must never hold at a clock edge outside reset
`define LEC_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// whenever ante holds, cons holds at the same edge
`define LEC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> hdl/lec_pkg.sv
// shared types and constants of the lightmap extent calculator
package lec_pkg;

  localparam int LUXEL_SIZE_DEF   = 16;
  localparam int EXTENT_LIMIT_DEF = 17;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam int COORD_W    = 32;
  localparam int PROJ_W     = 48;
  localparam int SIZE_W     = 5;
  localparam int CFG_REGS   = 8;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // 999999 and -99999 texels in Q40.8
  localparam logic signed [PROJ_W-1:0] MIN_INIT = 48'sd255999744;
  localparam logic signed [PROJ_W-1:0] MAX_INIT = -48'sd25599744;

  typedef enum logic [2:0] {
    REG_S_AXIS_X = 3'd0,
    REG_S_AXIS_Y = 3'd1,
    REG_S_AXIS_Z = 3'd2,
    REG_S_OFFSET = 3'd3,
    REG_T_AXIS_X = 3'd4,
    REG_T_AXIS_Y = 3'd5,
    REG_T_AXIS_Z = 3'd6,
    REG_T_OFFSET = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] off;
  } axis_cfg_t;

  typedef struct packed {
    axis_cfg_t s;
    axis_cfg_t t;
  } proj_cfg_t;

  // one projected vertex
  typedef struct packed {
    logic signed [PROJ_W-1:0] s;
    logic signed [PROJ_W-1:0] t;
    logic                     last;
  } proj_t;

  typedef struct packed {
    logic signed [PROJ_W-1:0] min_s;
    logic signed [PROJ_W-1:0] max_s;
    logic signed [PROJ_W-1:0] min_t;
    logic signed [PROJ_W-1:0] max_t;
  } bounds_t;

  localparam bounds_t BOUNDS_INIT = '{MIN_INIT, MAX_INIT, MIN_INIT, MAX_INIT};

endpackage

>>> hdl/lec_front.sv
// front end: projects each vertex onto the s and t axes
module lec_front (
  input  logic                      clk,
  input  logic                      rst,
  input  lec_pkg::proj_cfg_t        cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [31:0]        pos_x,
  input  logic signed [31:0]        pos_y,
  input  logic signed [31:0]        pos_z,
  input  logic                      last_vertex,
  output logic                      out_valid,
  input  logic                      out_ready,
  output lec_pkg::proj_t            out_item
);
  import lec_pkg::*;

  logic en;
  logic prod_valid, sum_valid, proj_valid;
  logic prod_last, sum_last;
  logic signed [63:0] prod_sx, prod_sy, prod_sz, prod_tx, prod_ty, prod_tz;
  logic signed [65:0] sum_s, sum_t;
  proj_t proj;

  function automatic logic signed [65:0] sum3(input logic signed [63:0] a,
                                              input logic signed [63:0] b,
                                              input logic signed [63:0] c);
    return {{2{a[63]}}, a} + {{2{b[63]}}, b} + {{2{c[63]}}, c};
  endfunction

  // floor of the Q.24 sum down to Q.8, then the shift
  function automatic logic signed [PROJ_W-1:0] scale(input logic signed [65:0] sum,
                                                      input logic signed [31:0] off);
    logic signed [49:0] whole;
    logic signed [49:0] total;
    whole = sum[65:16];
    total = whole + {{18{off[31]}}, off};
    return total[PROJ_W-1:0];
  endfunction

  assign en        = !proj_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = proj_valid;
  assign out_item  = proj;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      sum_valid  <= 1'b0;
      proj_valid <= 1'b0;
    end else if (en) begin
      prod_valid <= in_valid;
      sum_valid  <= prod_valid;
      proj_valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_sx   <= pos_x * cfg.s.ax;
      prod_sy   <= pos_y * cfg.s.ay;
      prod_sz   <= pos_z * cfg.s.az;
      prod_tx   <= pos_x * cfg.t.ax;
      prod_ty   <= pos_y * cfg.t.ay;
      prod_tz   <= pos_z * cfg.t.az;
      prod_last <= last_vertex;
      sum_s     <= sum3(prod_sx, prod_sy, prod_sz);
      sum_t     <= sum3(prod_tx, prod_ty, prod_tz);
      sum_last  <= prod_last;
      proj.s    <= scale(sum_s, cfg.s.off);
      proj.t    <= scale(sum_t, cfg.t.off);
      proj.last <= sum_last;
    end
  end

endmodule

>>> hdl/lec_queue.sv
// small fifo of projected vertices between front and back
`include "lightmap_extent_calc_defines.svh"

module lec_queue #(
  parameter int DEPTH = lec_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  lec_pkg::proj_t  in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output lec_pkg::proj_t  out_item
);
  import lec_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  proj_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic             push, pop;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= advance(wr_ptr);
      if (pop) rd_ptr <= advance(rd_ptr);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  `LEC_ASSERT_IMPLY(a_empty_ptrs, clk, rst, count == '0, wr_ptr == rd_ptr, "empty queue with pointers apart")
  `LEC_ASSERT_IMPLY(a_full_ptrs, clk, rst, count == CNT_W'(DEPTH), wr_ptr == rd_ptr, "full queue with pointers apart")

endmodule

>>> hdl/lec_size.sv
// one axis: bounds to lightmap size in luxels, five register stages
module lec_size #(
  parameter int LUXEL_SIZE   = lec_pkg::LUXEL_SIZE_DEF,
  parameter int EXTENT_LIMIT = lec_pkg::EXTENT_LIMIT_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [lec_pkg::PROJ_W-1:0] lo,
  input  logic signed [lec_pkg::PROJ_W-1:0] hi,
  output logic [lec_pkg::SIZE_W-1:0]        size,
  output logic                              err
);
  import lec_pkg::*;

  // exact reciprocal for operands below 2^RED_W
  localparam int RECIP_SHIFT = 27;
  localparam int RED_W       = 19;
  localparam int MULT_W      = 28;
  localparam int PROD_W      = RED_W + MULT_W;
  localparam int Q_W         = PROD_W - RECIP_SHIFT;
  localparam int L_W         = $clog2(LUXEL_SIZE + 1);
  localparam int RES_W       = L_W;
  localparam int QL_W        = Q_W + L_W;
  localparam int SPAN_W      = 42;
  localparam logic [MULT_W-1:0] RECIP_MULT =
    MULT_W'((1 << RECIP_SHIFT) / LUXEL_SIZE + 1);

  // residues of 256^k, and of the 2^39 bias of the offset-binary floor
  localparam int W0 = 1 % LUXEL_SIZE;
  localparam int W1 = 256 % LUXEL_SIZE;
  localparam int W2 = (W1 * 256) % LUXEL_SIZE;
  localparam int W3 = (W2 * 256) % LUXEL_SIZE;
  localparam int W4 = (W3 * 256) % LUXEL_SIZE;
  localparam int BIAS_RES = (W4 * 128) % LUXEL_SIZE;
  localparam int RES_OFS  = (LUXEL_SIZE - BIAS_RES) % LUXEL_SIZE;
  localparam int SPAN_LIMIT = (EXTENT_LIMIT - 1) * LUXEL_SIZE;

  logic [39:0]        lo_u;
  logic [48:0]        hi_up;
  logic [40:0]        hi_ceil;
  logic [RED_W-1:0]   res_sum_d;
  logic [SPAN_W-1:0]  span_d;

  logic [RED_W-1:0]   res_sum_a, res_sum_b;
  logic [SPAN_W-1:0]  span_a, span_b, span_c;
  logic [PROD_W-1:0]  prod1_b;
  logic [Q_W-1:0]     q1;
  logic [QL_W-1:0]    rem_full;
  logic [RES_W-1:0]   rm_c;
  logic [SPAN_W-1:0]  e;
  logic               err_d, err_e;
  logic [RED_W-1:0]   cval_d;
  logic [PROD_W-1:0]  prod2_e;
  logic [Q_W-1:0]     k;

  // floor(lo/256) in offset binary, ceil(hi/256)
  always_comb begin
    lo_u      = {~lo[PROJ_W-1], lo[PROJ_W-2:8]};
    hi_up     = {hi[PROJ_W-1], hi} + 49'd255;
    hi_ceil   = hi_up[48:8];
    res_sum_d = RED_W'(lo_u[7:0])   * RED_W'(W0)
              + RED_W'(lo_u[15:8])  * RED_W'(W1)
              + RED_W'(lo_u[23:16]) * RED_W'(W2)
              + RED_W'(lo_u[31:24]) * RED_W'(W3)
              + RED_W'(lo_u[39:32]) * RED_W'(W4)
              + RED_W'(RES_OFS);
    span_d    = {hi_ceil[40], hi_ceil} - {{2{lo[PROJ_W-1]}}, lo[PROJ_W-1:8]};
  end

  always_comb begin
    q1       = prod1_b[PROD_W-1:RECIP_SHIFT];
    rem_full = QL_W'(res_sum_b) - QL_W'(q1) * QL_W'(LUXEL_SIZE);
    e        = span_c + SPAN_W'(rm_c);
    k        = prod2_e[PROD_W-1:RECIP_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_sum_a <= res_sum_d;
      span_a    <= span_d;
      prod1_b   <= PROD_W'(res_sum_a) * PROD_W'(RECIP_MULT);
      res_sum_b <= res_sum_a;
      span_b    <= span_a;
      rm_c      <= rem_full[RES_W-1:0];
      span_c    <= span_b;
      err_d     <= e[SPAN_W-1] || (e > SPAN_W'(SPAN_LIMIT));
      cval_d    <= e[RED_W-1:0] + RED_W'(LUXEL_SIZE - 1);
      prod2_e   <= PROD_W'(cval_d) * PROD_W'(RECIP_MULT);
      err_e     <= err_d;
    end
  end

  assign size = SIZE_W'(k + Q_W'(1));
  assign err  = err_e;

endmodule

>>> hdl/lec_back.sv
// back end: running bounds per face, size pipeline and result register
`include "lightmap_extent_calc_defines.svh"

module lec_back #(
  parameter int LUXEL_SIZE   = lec_pkg::LUXEL_SIZE_DEF,
  parameter int EXTENT_LIMIT = lec_pkg::EXTENT_LIMIT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  lec_pkg::proj_t              in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lec_pkg::SIZE_W-1:0]  width_luxels,
  output logic [lec_pkg::SIZE_W-1:0]  height_luxels,
  output logic                        extent_error
);
  import lec_pkg::*;

  logic          en, pop;
  bounds_t       bounds, upd, snap;
  logic [5:0]    vld;
  logic [SIZE_W-1:0] size_s, size_t;
  logic          err_s, err_t, err_any;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign pop      = in_valid && en;
  assign err_any  = err_s || err_t;

  always_comb begin
    upd.min_s = (in_item.s < bounds.min_s) ? in_item.s : bounds.min_s;
    upd.max_s = (in_item.s > bounds.max_s) ? in_item.s : bounds.max_s;
    upd.min_t = (in_item.t < bounds.min_t) ? in_item.t : bounds.min_t;
    upd.max_t = (in_item.t > bounds.max_t) ? in_item.t : bounds.max_t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bounds    <= BOUNDS_INIT;
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        bounds <= in_item.last ? BOUNDS_INIT : upd;
      end
      if (en) begin
        vld       <= {vld[4:0], pop && in_item.last};
        out_valid <= vld[5];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      snap          <= upd;
      width_luxels  <= err_any ? '0 : size_s;
      height_luxels <= err_any ? '0 : size_t;
      extent_error  <= err_any;
    end
  end

  lec_size #(
    .LUXEL_SIZE   (LUXEL_SIZE),
    .EXTENT_LIMIT (EXTENT_LIMIT)
  ) u_size_s (
    .clk  (clk),
    .en   (en),
    .lo   (snap.min_s),
    .hi   (snap.max_s),
    .size (size_s),
    .err  (err_s)
  );

  lec_size #(
    .LUXEL_SIZE   (LUXEL_SIZE),
    .EXTENT_LIMIT (EXTENT_LIMIT)
  ) u_size_t (
    .clk  (clk),
    .en   (en),
    .lo   (snap.min_t),
    .hi   (snap.max_t),
    .size (size_t),
    .err  (err_t)
  );

  `LEC_ASSERT_IMPLY(a_err_zero, clk, rst, out_valid && extent_error, width_luxels == '0 && height_luxels == '0, "error result with nonzero size")
  `LEC_ASSERT_NEVER(a_no_pop_stalled, clk, rst, out_valid && !out_ready && pop, "vertex taken while result is stalled")

endmodule

>>> hdl/lightmap_extent_calc.sv
// top level of the lightmap extent calculator
//
//   channel   direction  handshake                  payload
//   in        sink       in_valid / in_ready        pos_x, pos_y, pos_z, last_vertex
//   out       source     out_valid / out_ready      width_luxels, height_luxels,
//                                                   extent_error
//   config    apb        psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// one vertex item per cycle while out_ready is high; the six projection multipliers
// are pipelined; a face result, once its last vertex is taken, passes through
//   3 projection stages, queue, bounds update, 5 size stages, result register
// rst is synchronous: config registers clear to 0, bounds re-arm, queue empties
// out_ready low holds the back end; the 4-deep queue absorbs the projection
//   pipeline, and in_ready drops only once the queue is full
`include "lightmap_extent_calc_defines.svh"

module lightmap_extent_calc #(
  parameter int LUXEL_SIZE   = lec_pkg::LUXEL_SIZE_DEF,
  parameter int EXTENT_LIMIT = lec_pkg::EXTENT_LIMIT_DEF,
  parameter int QUEUE_DEPTH  = lec_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // vertex items
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [31:0]               pos_x,
  input  logic signed [31:0]               pos_y,
  input  logic signed [31:0]               pos_z,
  input  logic                             last_vertex,
  // face results
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lec_pkg::SIZE_W-1:0]       width_luxels,
  output logic [lec_pkg::SIZE_W-1:0]       height_luxels,
  output logic                             extent_error,
  // register port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lec_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lec_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lec_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import lec_pkg::*;

  // texture axes and shifts, one word per register
  logic [APB_DATA_W-1:0] cfg [CFG_REGS];
  cfg_reg_e              reg_sel;
  proj_cfg_t             pcfg;

  // front to queue, queue to back
  logic  fq_valid, fq_ready, qb_valid, qb_ready;
  proj_t fq_item, qb_item;

  // register port: byte addresses on 4-byte steps, no wait states
  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[APB_ADDR_W-1:2]);
  assign prdata  = cfg[reg_sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CFG_REGS; i++) begin
        cfg[i] <= '0;
      end
    end else if (psel && penable && pwrite && pready) begin
      cfg[reg_sel] <= pwdata;
    end
  end

  always_comb begin
    pcfg.s.ax  = cfg[REG_S_AXIS_X];
    pcfg.s.ay  = cfg[REG_S_AXIS_Y];
    pcfg.s.az  = cfg[REG_S_AXIS_Z];
    pcfg.s.off = cfg[REG_S_OFFSET];
    pcfg.t.ax  = cfg[REG_T_AXIS_X];
    pcfg.t.ay  = cfg[REG_T_AXIS_Y];
    pcfg.t.az  = cfg[REG_T_AXIS_Z];
    pcfg.t.off = cfg[REG_T_OFFSET];
  end

  // projection of each vertex onto s and t
  lec_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (pcfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .last_vertex (last_vertex),
    .out_valid   (fq_valid),
    .out_ready   (fq_ready),
    .out_item    (fq_item)
  );

  // decouples projection from bounds tracking
  lec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_item   (fq_item),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_item  (qb_item)
  );

  // running min/max per face, then floor/ceil in luxels and the limit check
  lec_back #(
    .LUXEL_SIZE   (LUXEL_SIZE),
    .EXTENT_LIMIT (EXTENT_LIMIT)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (qb_valid),
    .in_ready      (qb_ready),
    .in_item       (qb_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .width_luxels  (width_luxels),
    .height_luxels (height_luxels),
    .extent_error  (extent_error)
  );

endmodule
